### hw/rtl/kuz_pkg.sv
// ----------------------------------------------------------------------------
// kuz_pkg: shared types, constants and functions for the Kuznyechik cipher
// Command codes, S-box tables, GF(2^8) multiply, linear layer helpers.
// ----------------------------------------------------------------------------
package kuz_pkg;

	localparam int unsigned KEY_HALVES = 20;
	localparam int unsigned NUM_KEYS   = 10;
	localparam int unsigned SLOT_W     = 5;
	localparam int unsigned KEY_W      = 4;

	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_ENCRYPT = 2'd1,
		CMD_DECRYPT = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	// controller to datapath
	typedef struct packed {
		logic             load_blk;  // capture input block
		logic             key_wr;    // write one key half
		logic             rd_en;     // read both halves of a round key
		logic [KEY_W-1:0] rd_key;    // round key number to read
		logic             do_round;  // apply one full round (key, S, L; or key, L^-1, S^-1 when inv)
		logic             do_final;  // apply final key XOR only
		logic             inv;       // decrypt direction
	} kuz_cmd_t;

	localparam logic [7:0] POLY_LOW = 8'hC3;

	localparam logic [7:0] LIN_COEF [16] = '{
		8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1, 8'd251,
		8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148, 8'd1
	};

	localparam logic [7:0] SBOX [256] = '{
		8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,8'd251,8'd196,8'd250,8'd218,
		8'd35,8'd197,8'd4,8'd77,8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,
		8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,8'd249,8'd24,8'd101,8'd90,
		8'd226,8'd92,8'd239,8'd33,8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
		8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,8'd6,8'd11,8'd237,8'd152,
		8'd127,8'd212,8'd211,8'd31,8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,
		8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,8'd181,8'd112,8'd14,8'd86,
		8'd8,8'd12,8'd118,8'd18,8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
		8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,8'd243,8'd145,8'd120,8'd111,
		8'd157,8'd158,8'd178,8'd177,8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,
		8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,8'd223,8'd245,8'd36,8'd169,
		8'd62,8'd168,8'd67,8'd201,8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
		8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,8'd220,8'd232,8'd40,8'd80,
		8'd78,8'd51,8'd10,8'd74,8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,
		8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,8'd173,8'd69,8'd70,8'd146,
		8'd39,8'd94,8'd85,8'd47,8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
		8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,8'd48,8'd55,8'd107,8'd228,
		8'd136,8'd217,8'd231,8'd137,8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,
		8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,8'd32,8'd113,8'd103,8'd164,
		8'd45,8'd43,8'd9,8'd91,8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
		8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,8'd209,8'd102,8'd175,8'd194,
		8'd57,8'd75,8'd99,8'd182
	};

	localparam logic [7:0] SBOX_INV [256] = '{
		8'd165,8'd45,8'd50,8'd143,8'd14,8'd48,8'd56,8'd192,8'd84,8'd230,8'd158,8'd57,
		8'd85,8'd126,8'd82,8'd145,8'd100,8'd3,8'd87,8'd90,8'd28,8'd96,8'd7,8'd24,
		8'd33,8'd114,8'd168,8'd209,8'd41,8'd198,8'd164,8'd63,8'd224,8'd39,8'd141,8'd12,
		8'd130,8'd234,8'd174,8'd180,8'd154,8'd99,8'd73,8'd229,8'd66,8'd228,8'd21,8'd183,
		8'd200,8'd6,8'd112,8'd157,8'd65,8'd117,8'd25,8'd201,8'd170,8'd252,8'd77,8'd191,
		8'd42,8'd115,8'd132,8'd213,8'd195,8'd175,8'd43,8'd134,8'd167,8'd177,8'd178,8'd91,
		8'd70,8'd211,8'd159,8'd253,8'd212,8'd15,8'd156,8'd47,8'd155,8'd67,8'd239,8'd217,
		8'd121,8'd182,8'd83,8'd127,8'd193,8'd240,8'd35,8'd231,8'd37,8'd94,8'd181,8'd30,
		8'd162,8'd223,8'd166,8'd254,8'd172,8'd34,8'd249,8'd226,8'd74,8'd188,8'd53,8'd202,
		8'd238,8'd120,8'd5,8'd107,8'd81,8'd225,8'd89,8'd163,8'd242,8'd113,8'd86,8'd17,
		8'd106,8'd137,8'd148,8'd101,8'd140,8'd187,8'd119,8'd60,8'd123,8'd40,8'd171,8'd210,
		8'd49,8'd222,8'd196,8'd95,8'd204,8'd207,8'd118,8'd44,8'd184,8'd216,8'd46,8'd54,
		8'd219,8'd105,8'd179,8'd20,8'd149,8'd190,8'd98,8'd161,8'd59,8'd22,8'd102,8'd233,
		8'd92,8'd108,8'd109,8'd173,8'd55,8'd97,8'd75,8'd185,8'd227,8'd186,8'd241,8'd160,
		8'd133,8'd131,8'd218,8'd71,8'd197,8'd176,8'd51,8'd250,8'd150,8'd111,8'd110,8'd194,
		8'd246,8'd80,8'd255,8'd93,8'd169,8'd142,8'd23,8'd27,8'd151,8'd125,8'd236,8'd88,
		8'd247,8'd31,8'd251,8'd124,8'd9,8'd13,8'd122,8'd103,8'd69,8'd135,8'd220,8'd232,
		8'd79,8'd29,8'd78,8'd4,8'd235,8'd248,8'd243,8'd62,8'd61,8'd189,8'd138,8'd136,
		8'd221,8'd205,8'd11,8'd19,8'd152,8'd2,8'd147,8'd128,8'd144,8'd208,8'd36,8'd52,
		8'd203,8'd237,8'd244,8'd206,8'd153,8'd16,8'd68,8'd64,8'd146,8'd58,8'd1,8'd38,
		8'd18,8'd26,8'd72,8'd104,8'd245,8'd129,8'd139,8'd199,8'd214,8'd32,8'd10,8'd8,
		8'd0,8'd76,8'd215,8'd116
	};

	// multiply by a constant in GF(2^8) mod x^8+x^7+x^6+x+1
	function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
		logic [7:0] acc;
		logic [7:0] xs;
		acc = '0;
		xs  = x;
		for (int i = 0; i < 8; i++) begin
			if (y[i])
				acc = acc ^ xs;
			xs = xs[7] ? ((xs << 1) ^ POLY_LOW) : (xs << 1);
		end
		return acc;
	endfunction

	// the 16x16 linear map L over bytes a15..a0 of a 128-bit word
	function automatic logic [127:0] lin_fwd(input logic [127:0] d);
		logic [7:0] b [32];
		logic [7:0] t;
		logic [127:0] r;
		for (int i = 0; i < 16; i++)
			b[i] = d[8*i +: 8];
		for (int i = 16; i < 32; i++)
			b[i] = 8'd0;
		// b[16+r] is the byte produced in step r; window slides up
		for (int s = 0; s < 16; s++) begin
			t = '0;
			for (int j = 0; j < 16; j++)
				t = t ^ gf_mul(b[s + 15 - j], LIN_COEF[j]);
			b[s + 16] = t;
		end
		for (int i = 0; i < 16; i++)
			r[8*i +: 8] = b[i + 16];
		return r;
	endfunction

	function automatic logic [127:0] lin_inv(input logic [127:0] d);
		logic [7:0] b [32];
		logic [7:0] t;
		logic [127:0] r;
		// b[16+i] = a_i; step s writes b[15-s], window slides down
		for (int i = 0; i < 16; i++)
			b[i + 16] = d[8*i +: 8];
		for (int i = 0; i < 16; i++)
			b[i] = 8'd0;
		for (int s = 0; s < 16; s++) begin
			t = gf_mul(b[31 - s], LIN_COEF[15]);
			for (int j = 0; j < 15; j++)
				t = t ^ gf_mul(b[30 - s - j], LIN_COEF[j]);
			b[15 - s] = t;
		end
		for (int i = 0; i < 16; i++)
			r[8*i +: 8] = b[i];
		return r;
	endfunction

endpackage

### hw/rtl/kuznyechik_block_cipher.sv
// ----------------------------------------------------------------------------
// kuznyechik_block_cipher: GOST R 34.12-2015 block cipher, 128-bit
// Key store of ten round keys, iterative round unit, valid/ready channels.
// ----------------------------------------------------------------------------
// An encrypt or decrypt transaction reads the first round key from the key
// store in the cycle the transaction is accepted; then nine full rounds and
// one final key XOR follow, one per cycle, through a single shared round
// unit. A load transaction with key_slot below 20 writes one key half in the
// cycle it is accepted and returns nothing; loads to slots 20 to 31 and
// command 3 are dropped. The next transaction is accepted in the
// cycle the result is taken. The key store
// is not cleared: every half must be loaded before it is used. Bytes run
// a15 (top of data_hi) down to a0 (bottom of data_lo).
module kuznyechik_block_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [4:0]  key_slot,
	input  logic [63:0] data_hi,
	input  logic [63:0] data_lo,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] block_hi,
	output logic [63:0] block_lo
);

	kuz_pkg::kuz_cmd_t cmd;
	logic [127:0]      state;

	// sequencer: handshakes and round key order
	kuz_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.valid_in(in_valid), .ready_in(in_ready),
		.command(command), .key_slot(key_slot),
		.valid_out(out_valid), .ready_out(out_ready),
		.cmd(cmd)
	);

	// key store, block register and round logic
	kuz_datapath u_dp (
		.clk(clk), .cmd(cmd), .key_slot(key_slot),
		.data_hi(data_hi), .data_lo(data_lo),
		.state(state)
	);

	// block register holds the result until taken
	assign block_hi = state[127:64];
	assign block_lo = state[63:0];

endmodule

### hw/rtl/kuz_ram.sv
// ----------------------------------------------------------------------------
// kuz_ram: generic single-port-write, single-read RAM
// Registered read; contents undefined until written.
// ----------------------------------------------------------------------------
module kuz_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 10
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### hw/rtl/kuz_datapath.sv
// ----------------------------------------------------------------------------
// kuz_datapath: key store and round unit
// Two RAM banks hold upper and lower key halves; one round per cycle.
// ----------------------------------------------------------------------------
module kuz_datapath (
	input  logic              clk,
	input  kuz_pkg::kuz_cmd_t cmd,
	input  logic [4:0]        key_slot,
	input  logic [63:0]       data_hi,
	input  logic [63:0]       data_lo,
	output logic [127:0]      state
);

	logic [127:0] state_q;
	logic [127:0] rkey;
	logic [127:0] x;
	logic [127:0] sub;
	logic [127:0] fwd;
	logic [127:0] lin;
	logic [127:0] bwd;
	logic [63:0]  key_hi;
	logic [63:0]  key_lo;
	logic         wr_hi;
	logic         wr_lo;

	assign wr_hi = cmd.key_wr && !key_slot[0];
	assign wr_lo = cmd.key_wr && key_slot[0];

	kuz_ram #(.WIDTH(64), .DEPTH(kuz_pkg::NUM_KEYS)) u_ram_hi (
		.clk(clk), .wr_en(wr_hi), .wr_addr(key_slot[4:1]), .wr_data(data_hi),
		.rd_en(cmd.rd_en), .rd_addr(cmd.rd_key), .rd_data(key_hi)
	);

	kuz_ram #(.WIDTH(64), .DEPTH(kuz_pkg::NUM_KEYS)) u_ram_lo (
		.clk(clk), .wr_en(wr_lo), .wr_addr(key_slot[4:1]), .wr_data(data_hi),
		.rd_en(cmd.rd_en), .rd_addr(cmd.rd_key), .rd_data(key_lo)
	);

	assign rkey = {key_hi, key_lo};
	assign x    = state_q ^ rkey;

	// forward: S then L; inverse: L^-1 then S^-1
	always_comb begin
		for (int i = 0; i < 16; i++)
			sub[8*i +: 8] = kuz_pkg::SBOX[x[8*i +: 8]];
		fwd = kuz_pkg::lin_fwd(sub);
		lin = kuz_pkg::lin_inv(x);
		for (int i = 0; i < 16; i++)
			bwd[8*i +: 8] = kuz_pkg::SBOX_INV[lin[8*i +: 8]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_blk)
			state_q <= {data_hi, data_lo};
		else if (cmd.do_round)
			state_q <= cmd.inv ? bwd : fwd;
		else if (cmd.do_final)
			state_q <= x;
	end

	assign state = state_q;

endmodule

### hw/rtl/kuz_ctrl.sv
// ----------------------------------------------------------------------------
// kuz_ctrl: cipher sequencer
// Accepts transactions, steps ten round keys, holds the result for output.
// ----------------------------------------------------------------------------
module kuz_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_in,
	output logic              ready_in,
	input  logic [1:0]        command,
	input  logic [4:0]        key_slot,
	output logic              valid_out,
	input  logic              ready_out,
	output kuz_pkg::kuz_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t                      state_q;
	logic [kuz_pkg::KEY_W-1:0]   cnt_q;   // rounds applied so far
	logic                        inv_q;
	logic                        valid_out_q;
	logic                        accept;
	logic                        start;
	logic [kuz_pkg::KEY_W-1:0]   next_key;
	logic                        last;

	assign ready_in  = (state_q == ST_IDLE) || (state_q == ST_DONE && ready_out);
	assign accept    = valid_in && ready_in;
	assign start     = accept && (command == kuz_pkg::CMD_ENCRYPT ||
		command == kuz_pkg::CMD_DECRYPT);
	assign valid_out = valid_out_q;
	assign last      = (cnt_q == 4'(kuz_pkg::NUM_KEYS - 1));

	// key for the round after cnt_q+1 rounds, prefetched through the registered RAM read
	always_comb begin
		if (start)
			next_key = (command == kuz_pkg::CMD_DECRYPT) ?
				4'(kuz_pkg::NUM_KEYS - 1) : 4'd0;
		else
			next_key = inv_q ? 4'(kuz_pkg::NUM_KEYS - 2) - cnt_q : cnt_q + 4'd1;
	end

	always_comb begin
		cmd          = '0;
		cmd.load_blk = start;
		cmd.key_wr   = accept && command == kuz_pkg::CMD_LOAD &&
			key_slot < 5'(kuz_pkg::KEY_HALVES);
		cmd.rd_en    = start || (state_q == ST_RUN && !last);
		cmd.rd_key   = next_key;
		cmd.do_round = state_q == ST_RUN && !last;
		cmd.do_final = state_q == ST_RUN && last;
		cmd.inv      = inv_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			inv_q       <= 1'b0;
			valid_out_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE, ST_DONE: begin
					if (state_q == ST_DONE && ready_out) begin
						valid_out_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
					if (start) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
						inv_q   <= command == kuz_pkg::CMD_DECRYPT;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 4'd1;
					if (last) begin
						state_q     <= ST_DONE;
						valid_out_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_valid_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out |-> state_q == ST_DONE)
		else $error("result valid outside done state");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> cnt_q < 4'(kuz_pkg::NUM_KEYS))
		else $error("round count out of range");
	a_no_accept_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> !ready_in)
		else $error("input taken while rounds run");
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN && last |=> valid_out)
		else $error("last round did not raise result");
`endif

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for kuznyechik_block_cipher
// Loads round key halves, encrypts and decrypts blocks under random sender
// bursts and receiver stalls, and checks every block against a local cipher
// model that tracks the key store as load transactions are accepted.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int LONG_HOLD   = 300;
	localparam int TAIL_CYCLES = 30;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  command = kuz_pkg::CMD_NONE;
	logic [4:0]  key_slot = '0;
	logic [63:0] data_hi = '0;
	logic [63:0] data_lo = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] block_hi;
	logic [63:0] block_lo;

	// local copy of the round key store, updated on accepted loads
	logic [63:0]  key_half [kuz_pkg::KEY_HALVES];
	// blocks still owed by the block, oldest first
	logic [127:0] pending_blocks [$];
	int           errors = 0;
	int           cycles = 0;
	int           burst_left = 0;
	// receiver long hold-off, requested by a test, counted by the receiver
	logic         hold_req = 1'b0;
	int           hold_cnt = 0;

	kuznyechik_block_cipher dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.key_slot (key_slot),
		.data_hi  (data_hi),
		.data_lo  (data_lo),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.block_hi (block_hi),
		.block_lo (block_lo)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Cipher model
	// ------------------------------------------------------------------

	// GF(2^8) product, field polynomial x^8+x^7+x^6+x+1
	function automatic logic [7:0] field_mul(logic [7:0] a, logic [7:0] b);
		logic [7:0] acc;
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				acc ^= a;
			a = a[7] ? ((a << 1) ^ 8'hC3) : (a << 1);
		end
		return acc;
	endfunction

	// sixteen LFSR-like steps; new byte enters at a15
	function automatic logic [127:0] mix_forward(logic [127:0] a);
		logic [7:0] t;
		for (int r = 0; r < 16; r++) begin
			t = '0;
			for (int j = 0; j < 16; j++)
				t ^= field_mul(a[8*(15-j) +: 8], kuz_pkg::LIN_COEF[j]);
			a = {t, a[127:8]};
		end
		return a;
	endfunction

	// undo of mix_forward; new byte enters at a0
	function automatic logic [127:0] mix_inverse(logic [127:0] a);
		logic [7:0] t;
		for (int r = 0; r < 16; r++) begin
			t = field_mul(a[127:120], kuz_pkg::LIN_COEF[15]);
			for (int j = 0; j < 15; j++)
				t ^= field_mul(a[8*(14-j) +: 8], kuz_pkg::LIN_COEF[j]);
			a = {a[119:0], t};
		end
		return a;
	endfunction

	function automatic logic [127:0] round_key(int k);
		return {key_half[2*k], key_half[2*k+1]};
	endfunction

	function automatic logic [127:0] cipher_block(logic [1:0] op, logic [127:0] a);
		if (op == kuz_pkg::CMD_ENCRYPT) begin
			for (int k = 0; k < kuz_pkg::NUM_KEYS - 1; k++) begin
				a ^= round_key(k);
				for (int i = 0; i < 16; i++)
					a[8*i +: 8] = kuz_pkg::SBOX[a[8*i +: 8]];
				a = mix_forward(a);
			end
			a ^= round_key(kuz_pkg::NUM_KEYS - 1);
		end else begin
			for (int k = kuz_pkg::NUM_KEYS - 1; k > 0; k--) begin
				a ^= round_key(k);
				a = mix_inverse(a);
				for (int i = 0; i < 16; i++)
					a[8*i +: 8] = kuz_pkg::SBOX_INV[a[8*i +: 8]];
			end
			a ^= round_key(0);
		end
		return a;
	endfunction

	// ------------------------------------------------------------------
	// Sender: one transaction, called at a rising edge. Valid stays up
	// across a burst; a gap drops it for a random number of cycles.
	// ------------------------------------------------------------------
	task automatic send_item(logic [1:0] op, logic [4:0] slot, logic [63:0] hi,
			logic [63:0] lo);
		int gap;
		in_valid <= 1'b1;
		command  <= op;
		key_slot <= slot;
		data_hi  <= hi;
		data_lo  <= lo;
		do
			@(posedge clk);
		while (!in_ready);
		// transaction accepted at this edge: update model
		if (op == kuz_pkg::CMD_LOAD && slot < kuz_pkg::KEY_HALVES)
			key_half[slot] = hi;
		else if (op == kuz_pkg::CMD_ENCRYPT || op == kuz_pkg::CMD_DECRYPT)
			pending_blocks.push_back(cipher_block(op, {hi, lo}));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// stop offering and wait for every owed block, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_blocks.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// data with the extremes showing up now and then
	function automatic logic [63:0] rand_data();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return rand64();
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// fill every key half; halves 0 and 1 take the extremes
	task automatic test_key_load();
		for (int s = 0; s < kuz_pkg::KEY_HALVES; s++) begin
			logic [63:0] v;
			v = (s == 0) ? '0 : (s == 1) ? '1 : rand64();
			send_item(kuz_pkg::CMD_LOAD, s[4:0], v, rand64());
		end
	endtask

	// extremes of the block, both directions, and the dropped cases
	task automatic test_directed();
		send_item(kuz_pkg::CMD_ENCRYPT, 5'd0, '0, '0);
		send_item(kuz_pkg::CMD_ENCRYPT, 5'd31, '1, '1);
		send_item(kuz_pkg::CMD_DECRYPT, 5'd0, '0, '0);
		send_item(kuz_pkg::CMD_DECRYPT, 5'd31, '1, '1);
		// loads outside the store must leave it alone
		send_item(kuz_pkg::CMD_LOAD, 5'd20, '1, '1);
		send_item(kuz_pkg::CMD_LOAD, 5'd31, '1, '0);
		send_item(kuz_pkg::CMD_NONE, 5'd0, '1, '1);
		send_item(kuz_pkg::CMD_ENCRYPT, 5'd19, 64'h1122334455667700,
			64'hffeeddccbbaa9988);
		send_item(kuz_pkg::CMD_DECRYPT, 5'd7, 64'h7f679d90bebc2430,
			64'h5a468d42b9d4edcd);
		drain();
	endtask

	// receiver holds off long enough to back up the input
	task automatic test_backpressure();
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		for (int i = 0; i < 12; i++)
			send_item(($urandom_range(0, 1) != 0) ? kuz_pkg::CMD_ENCRYPT :
				kuz_pkg::CMD_DECRYPT, 5'($urandom), rand64(), rand64());
		drain();
	endtask

	// mostly cipher traffic with key rewrites, stray loads and dropped commands
	task automatic test_random(int count);
		int pick;
		logic [1:0] op;
		logic [4:0] slot;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			slot = 5'($urandom);
			if (pick < 40)
				op = kuz_pkg::CMD_ENCRYPT;
			else if (pick < 80)
				op = kuz_pkg::CMD_DECRYPT;
			else if (pick < 92) begin
				op = kuz_pkg::CMD_LOAD;
				slot = 5'($urandom_range(0, kuz_pkg::KEY_HALVES - 1));
			end else if (pick < 96) begin
				op = kuz_pkg::CMD_LOAD;
				slot = 5'($urandom_range(kuz_pkg::KEY_HALVES, 31));
			end else
				op = kuz_pkg::CMD_NONE;
			send_item(op, slot, rand_data(), rand_data());
			if (i % 500 == 499)
				drain();
		end
		drain();
	endtask

	// ------------------------------------------------------------------
	// Receiver: stall pattern steps through four phases, plus the long hold
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_req) begin
			hold_cnt  <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt  <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else begin
			case ((cycles / 64) % 4)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) != 0);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// result checker: each accepted block against the oldest expectation
	always @(posedge clk) begin
		logic [127:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_blocks.size() == 0) begin
				$display("%0t: unexpected block %h_%h", $time, block_hi, block_lo);
				errors++;
			end else begin
				want = pending_blocks.pop_front();
				if (block_hi !== want[127:64]) begin
					$display("%0t: block_hi expected %h actual %h", $time,
						want[127:64], block_hi);
					errors++;
				end
				if (block_lo !== want[63:0]) begin
					$display("%0t: block_lo expected %h actual %h", $time,
						want[63:0], block_lo);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_key_load();
		test_directed();
		test_backpressure();
		test_random(1900);
		if (pending_blocks.size() != 0) begin
			$display("%0t: %0d blocks never arrived", $time, pending_blocks.size());
			errors++;
		end
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
